// ----- hw/rtl/cc20ks_pkg.sv -----
// shared types, constants and helper functions for the chacha20 keystream block
package cc20ks_pkg;

    // number of double rounds, also the number of cells in the round ring
    localparam int DOUBLE_ROUNDS = 10;
    // one cell step is a quarter of a round, eight steps make one double round
    localparam int TOTAL_STEPS   = 8 * DOUBLE_ROUNDS;
    localparam int STEP_W        = $clog2(TOTAL_STEPS + 1);

    localparam int CHUNKS        = 8;
    localparam int CHUNK_IDX_W   = 3;

    // configuration port geometry, registers are 64 bits at 8-byte spacing
    localparam int PADDR_W       = 6;
    localparam int PDATA_W       = 64;

    typedef logic [31:0]       word_t;
    typedef logic [15:0][31:0] state_t;

    // ChaCha constant words "expand 32-byte k"
    localparam word_t SIGMA0 = 32'h6170_7865;
    localparam word_t SIGMA1 = 32'h3320_646e;
    localparam word_t SIGMA2 = 32'h7962_2d32;
    localparam word_t SIGMA3 = 32'h6b20_6574;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_KEY_PART0  = 3'd0,
        REG_KEY_PART1  = 3'd1,
        REG_KEY_PART2  = 3'd2,
        REG_KEY_PART3  = 3'd3,
        REG_NONCE_LOW  = 3'd4,
        REG_NONCE_HIGH = 3'd5
    } reg_index_t;

    // which quarter of the quarter round a cell applies
    typedef enum logic [1:0] {
        SUB_AD16 = 2'd0,
        SUB_CB12 = 2'd1,
        SUB_AD8  = 2'd2,
        SUB_CB7  = 2'd3
    } sub_step_t;

    // key and nonce as held by the configuration registers
    typedef struct packed {
        logic [63:0] key_part0;
        logic [63:0] key_part1;
        logic [63:0] key_part2;
        logic [63:0] key_part3;
        logic [63:0] nonce_low;
        logic [31:0] nonce_high;
    } cfg_t;

    // one block in flight through the ring
    typedef struct packed {
        logic              valid;
        logic [STEP_W-1:0] step;
        word_t             ctr;
        state_t            st;
    } slot_t;

    function automatic word_t rotl(word_t v, int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // initial 16-word state from constants, key, counter and nonce
    function automatic state_t init_state(cfg_t c, word_t ctr);
        state_t s;
        s[0]  = SIGMA0;
        s[1]  = SIGMA1;
        s[2]  = SIGMA2;
        s[3]  = SIGMA3;
        s[4]  = c.key_part0[31:0];
        s[5]  = c.key_part0[63:32];
        s[6]  = c.key_part1[31:0];
        s[7]  = c.key_part1[63:32];
        s[8]  = c.key_part2[31:0];
        s[9]  = c.key_part2[63:32];
        s[10] = c.key_part3[31:0];
        s[11] = c.key_part3[63:32];
        s[12] = ctr;
        s[13] = c.nonce_low[31:0];
        s[14] = c.nonce_low[63:32];
        s[15] = c.nonce_high;
        return s;
    endfunction

endpackage

// ----- hw/rtl/chacha20_keystream_block_top.sv -----
// ChaCha20 keystream block: round ring, configuration registers and output stage
// flow: an accepted counter transaction enters cell 0 and laps the ring to its final step,
//   then the output stage sends one 64-bit chunk per cycle while ks_stall is low,
//   eight chunks per block; the sustained block rate is set by the 64-bit output port;
//   the ring of DOUBLE_ROUNDS cells holds up to DOUBLE_ROUNDS blocks, each making 8 laps
// reset: rst_n asynchronous active low; clears key and nonce to zero, empties the ring
//   and the output stage
module chacha20_keystream_block_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // counter channel
    input  logic                               ctr_valid,
    output logic                               ctr_stall,
    input  logic [31:0]                        block_counter,
    // keystream channel
    output logic                               ks_valid,
    input  logic                               ks_stall,
    output logic [63:0]                        keystream_chunk,
    output logic [cc20ks_pkg::CHUNK_IDX_W-1:0] chunk_index,
    output logic                               last_chunk,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cc20ks_pkg::PADDR_W-1:0]     paddr,
    input  logic [cc20ks_pkg::PDATA_W-1:0]     pwdata,
    output logic [cc20ks_pkg::PDATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int NCELL = cc20ks_pkg::DOUBLE_ROUNDS;
    localparam logic [cc20ks_pkg::STEP_W-1:0] DONE_STEP =
        cc20ks_pkg::STEP_W'(cc20ks_pkg::TOTAL_STEPS);

    logic [63:0]            key_part0_reg;
    logic [63:0]            key_part1_reg;
    logic [63:0]            key_part2_reg;
    logic [63:0]            key_part3_reg;
    logic [63:0]            nonce_low_reg;
    logic [31:0]            nonce_high_reg;
    cc20ks_pkg::cfg_t       cfg;
    cc20ks_pkg::reg_index_t reg_idx;
    logic                   cfg_wr;

    cc20ks_pkg::slot_t      slot_q [NCELL];
    cc20ks_pkg::slot_t      inject;
    cc20ks_pkg::slot_t      last_slot;
    logic                   last_done;
    logic                   last_wrap;
    logic                   ring_en;
    logic                   can_load;
    logic                   load;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_idx = cc20ks_pkg::reg_index_t'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_part0_reg  <= '0;
            key_part1_reg  <= '0;
            key_part2_reg  <= '0;
            key_part3_reg  <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                cc20ks_pkg::REG_KEY_PART0:  key_part0_reg  <= pwdata;
                cc20ks_pkg::REG_KEY_PART1:  key_part1_reg  <= pwdata;
                cc20ks_pkg::REG_KEY_PART2:  key_part2_reg  <= pwdata;
                cc20ks_pkg::REG_KEY_PART3:  key_part3_reg  <= pwdata;
                cc20ks_pkg::REG_NONCE_LOW:  nonce_low_reg  <= pwdata;
                cc20ks_pkg::REG_NONCE_HIGH: nonce_high_reg <= pwdata[31:0];
                default:                    ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            cc20ks_pkg::REG_KEY_PART0:  prdata = key_part0_reg;
            cc20ks_pkg::REG_KEY_PART1:  prdata = key_part1_reg;
            cc20ks_pkg::REG_KEY_PART2:  prdata = key_part2_reg;
            cc20ks_pkg::REG_KEY_PART3:  prdata = key_part3_reg;
            cc20ks_pkg::REG_NONCE_LOW:  prdata = nonce_low_reg;
            cc20ks_pkg::REG_NONCE_HIGH: prdata = {32'd0, nonce_high_reg};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.key_part0  = key_part0_reg;
    assign cfg.key_part1  = key_part1_reg;
    assign cfg.key_part2  = key_part2_reg;
    assign cfg.key_part3  = key_part3_reg;
    assign cfg.nonce_low  = nonce_low_reg;
    assign cfg.nonce_high = nonce_high_reg;

    // ring control: a finished block leaves from the last cell, others wrap around
    assign last_slot = slot_q[NCELL-1];
    assign last_done = last_slot.valid && (last_slot.step == DONE_STEP);
    assign last_wrap = last_slot.valid && !last_done;
    assign load      = last_done && can_load;
    assign ring_en   = !(last_done && !can_load);
    assign ctr_stall = !ring_en || last_wrap;

    // cell 0 takes the wrapping block or a new counter transaction
    always_comb
    begin
        if (last_wrap)
        begin
            inject = last_slot;
        end
        else
        begin
            inject.valid = ctr_valid;
            inject.step  = '0;
            inject.ctr   = block_counter;
            inject.st    = cc20ks_pkg::init_state(cfg, block_counter);
        end
    end

    // the ring of round cells
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            cc20ks_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (ring_en),
                .slot_in  (inject),
                .slot_out (slot_q[k])
            );
        end
        else
        begin : g_body
            cc20ks_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (ring_en),
                .slot_in  (slot_q[k-1]),
                .slot_out (slot_q[k])
            );
        end
    end

    // feed-forward and chunk output
    cc20ks_outbuf u_outbuf (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (load),
        .blk             (last_slot),
        .cfg             (cfg),
        .can_load        (can_load),
        .ks_valid        (ks_valid),
        .ks_stall        (ks_stall),
        .keystream_chunk (keystream_chunk),
        .chunk_index     (chunk_index),
        .last_chunk      (last_chunk)
    );

    // a finished block waiting on the output stage holds in the last cell
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (last_done && !ring_en) |=> (last_done && $stable(last_slot.ctr)))
        else $error("finished block lost while ring frozen");

    // an accepted counter enters cell 0 after its first step
    a_inject: assert property (@(posedge clk) disable iff (!rst_n)
        (ctr_valid && !ctr_stall) |=>
            (slot_q[0].valid && slot_q[0].step == 1 &&
             slot_q[0].ctr == $past(block_counter)))
        else $error("counter transaction not placed in ring");

    // chunks of one block come out in order without gaps in numbering
    a_chunk_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (ks_valid && !ks_stall && !last_chunk) |=>
            (ks_valid && chunk_index == cc20ks_pkg::CHUNK_IDX_W'($past(chunk_index) + 1'b1)))
        else $error("keystream chunk sequence broken");

    // the last cell never holds a block past its final step
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        last_slot.valid |-> (last_slot.step != 0 && last_slot.step <= DONE_STEP))
        else $error("step count out of range in last cell");

endmodule

// ----- hw/rtl/cc20ks_cell.sv -----
// one ring cell: applies one quarter-round step to all four lanes per cycle while en is high
module cc20ks_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  cc20ks_pkg::slot_t slot_in,
    output cc20ks_pkg::slot_t slot_out
);

    logic                          valid_reg;
    logic [cc20ks_pkg::STEP_W-1:0] step_reg;
    cc20ks_pkg::word_t             ctr_reg;
    cc20ks_pkg::state_t            st_reg;

    logic                          diag;
    cc20ks_pkg::sub_step_t         sub;
    logic [3:0][31:0]              va, vb, vc, vd;
    logic [3:0][31:0]              na, nb, nc, nd;
    cc20ks_pkg::state_t            st_next;
    logic [cc20ks_pkg::STEP_W-1:0] step_next;

    // step code: bit 2 picks diagonal rounds, bits 1:0 the quarter-round phase
    assign diag      = slot_in.step[2];
    assign sub       = cc20ks_pkg::sub_step_t'(slot_in.step[1:0]);
    assign step_next = slot_in.step + 1'b1;

    // gather the lane operands, diagonals taken from rotated columns
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            va[j] = slot_in.st[j];
            vb[j] = diag ? slot_in.st[4 + ((j + 1) % 4)]  : slot_in.st[4 + j];
            vc[j] = diag ? slot_in.st[8 + ((j + 2) % 4)]  : slot_in.st[8 + j];
            vd[j] = diag ? slot_in.st[12 + ((j + 3) % 4)] : slot_in.st[12 + j];
        end
    end

    // one add, xor and rotate per lane
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            na[j] = va[j];
            nb[j] = vb[j];
            nc[j] = vc[j];
            nd[j] = vd[j];
            case (sub)
                cc20ks_pkg::SUB_AD16:
                begin
                    na[j] = va[j] + vb[j];
                    nd[j] = cc20ks_pkg::rotl(vd[j] ^ na[j], 16);
                end
                cc20ks_pkg::SUB_CB12:
                begin
                    nc[j] = vc[j] + vd[j];
                    nb[j] = cc20ks_pkg::rotl(vb[j] ^ nc[j], 12);
                end
                cc20ks_pkg::SUB_AD8:
                begin
                    na[j] = va[j] + vb[j];
                    nd[j] = cc20ks_pkg::rotl(vd[j] ^ na[j], 8);
                end
                cc20ks_pkg::SUB_CB7:
                begin
                    nc[j] = vc[j] + vd[j];
                    nb[j] = cc20ks_pkg::rotl(vb[j] ^ nc[j], 7);
                end
                default:
                begin
                    na[j] = va[j];
                end
            endcase
        end
    end

    // scatter lane results back to their state words
    always_comb
    begin
        for (int m = 0; m < 4; m++)
        begin
            st_next[m]      = na[m];
            st_next[4 + m]  = diag ? nb[(m + 3) % 4] : nb[m];
            st_next[8 + m]  = diag ? nc[(m + 2) % 4] : nc[m];
            st_next[12 + m] = diag ? nd[(m + 1) % 4] : nd[m];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else if (en)
        begin
            valid_reg <= slot_in.valid;
            step_reg  <= step_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctr_reg <= slot_in.ctr;
            st_reg  <= st_next;
        end
    end

    assign slot_out.valid = valid_reg;
    assign slot_out.step  = step_reg;
    assign slot_out.ctr   = ctr_reg;
    assign slot_out.st    = st_reg;

endmodule

// ----- hw/rtl/cc20ks_outbuf.sv -----
// output stage: adds the initial state back in and sends eight 64-bit chunks
module cc20ks_outbuf (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  cc20ks_pkg::slot_t                  blk,
    input  cc20ks_pkg::cfg_t                   cfg,
    output logic                               can_load,
    output logic                               ks_valid,
    input  logic                               ks_stall,
    output logic [63:0]                        keystream_chunk,
    output logic [cc20ks_pkg::CHUNK_IDX_W-1:0] chunk_index,
    output logic                               last_chunk
);

    localparam logic [cc20ks_pkg::CHUNK_IDX_W-1:0] LAST_IDX =
        cc20ks_pkg::CHUNK_IDX_W'(cc20ks_pkg::CHUNKS - 1);

    logic                                  busy_reg, busy_next;
    logic [cc20ks_pkg::CHUNK_IDX_W-1:0]    idx_reg, idx_next;
    logic [cc20ks_pkg::CHUNKS-1:0][63:0]   chunks_reg;
    logic [cc20ks_pkg::CHUNKS-1:0][63:0]   chunks_load;
    cc20ks_pkg::state_t                    init_st;
    cc20ks_pkg::state_t                    sum_st;
    logic                                  drain;
    logic                                  drain_last;

    // feed-forward add of the original state
    assign init_st = cc20ks_pkg::init_state(cfg, blk.ctr);

    always_comb
    begin
        for (int w = 0; w < 16; w++)
        begin
            sum_st[w] = init_st[w] + blk.st[w];
        end
        for (int k = 0; k < cc20ks_pkg::CHUNKS; k++)
        begin
            chunks_load[k] = {sum_st[2 * k + 1], sum_st[2 * k]};
        end
    end

    // output transaction bookkeeping
    assign drain      = busy_reg && !ks_stall;
    assign drain_last = drain && (idx_reg == LAST_IDX);
    assign can_load   = !busy_reg || drain_last;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (drain)
        begin
            idx_next = idx_reg + 1'b1;
            if (drain_last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // chunk shift line, head is the chunk on offer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chunks_reg <= chunks_load;
        end
        else if (drain)
        begin
            for (int k = 0; k < cc20ks_pkg::CHUNKS - 1; k++)
            begin
                chunks_reg[k] <= chunks_reg[k + 1];
            end
        end
    end

    assign ks_valid        = busy_reg;
    assign keystream_chunk = chunks_reg[0];
    assign chunk_index     = idx_reg;
    assign last_chunk      = (idx_reg == LAST_IDX);

endmodule
